FILE: hw/rtl/pdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pdc_pkg;

  localparam int FRAC_BITS = 24;
  localparam int RATE_W    = 32;
  localparam int REF_W     = 6;
  localparam int VMIN_W    = 12;
  localparam int R_W       = 13;
  localparam int MUL_W     = 16;
  localparam int DP_W      = 3;
  localparam int FB_W      = 11;
  localparam int FRAC_W    = 24;
  localparam int ST_W      = 2;
  localparam int K_W       = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 12;
  localparam int RECIP_W   = 31;
  localparam int PROD_W    = RATE_W + RECIP_W;
  localparam int RECIP_SHIFT = 50;
  localparam int NUM_MUL   = 8;

  localparam int MAIN_W      = R_W + FRAC_BITS;
  localparam int MAIN_STEPS  = MAIN_W;
  localparam int GCD_START   = R_W;
  localparam int GCD_STEPS   = 2 * REF_W;
  localparam int QUO_START   = GCD_START + GCD_STEPS + 1;
  localparam int QUO_STEPS   = R_W;
  localparam int QUO_END     = QUO_START + QUO_STEPS;
  localparam int CORE_STAGES = (MAIN_STEPS > QUO_END) ? MAIN_STEPS : QUO_END;

  localparam logic [RATE_W-1:0]  MAX_RATE_HZ = 32'd3200000000;
  localparam logic [RECIP_W-1:0] RECIP_MHZ   = 31'h431BDE83;
  localparam logic [FB_W-1:0]    MAX_FB_DIV  = 11'h7ff;
  localparam int                 MAX_POST_DIV = 7;
  localparam logic [REF_W-1:0]   REF_CLOCK_RST = 6'd25;
  localparam logic [VMIN_W-1:0]  VCO_MIN_RST   = 12'd800;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_TOO_HIGH = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_CLOCK = 1'd0,
    REG_VCO_MIN   = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [REF_W-1:0] a;
    logic [REF_W-1:0] b;
    logic [K_W-1:0]   k;
  } gcd_t;

  typedef struct packed {
    logic              valid;
    status_t           status;
    logic              pll;
    logic [DP_W-1:0]   dp;
    logic [R_W-1:0]    r2;
    logic [REF_W-1:0]  rem;
    logic [MAIN_W-1:0] main_q;
    gcd_t              gcd;
    logic [REF_W-1:0]  gdiv;
    logic [REF_W-1:0]  rem_n;
    logic [R_W-1:0]    quo_n;
    logic [REF_W-1:0]  rem_m;
    logic [R_W-1:0]    quo_m;
  } core_t;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [REF_W:0] div_step(input logic [REF_W-1:0] rem,
                                              input logic din,
                                              input logic [REF_W-1:0] d);
    logic [REF_W:0] t;
    t = {rem, din};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, REF_W'(t - {1'b0, d})};
    end else begin
      div_step = {1'b0, t[REF_W-1:0]};
    end
  endfunction

  // one binary gcd step
  function automatic gcd_t gcd_step(input gcd_t g);
    gcd_t n;
    n = g;
    if (g.a == '0 || g.b == '0) begin
      n = g;
    end else if (!g.a[0] && !g.b[0]) begin
      n.a = g.a >> 1;
      n.b = g.b >> 1;
      n.k = g.k + K_W'(1);
    end else if (!g.a[0]) begin
      n.a = g.a >> 1;
    end else if (!g.b[0]) begin
      n.b = g.b >> 1;
    end else if (g.a >= g.b) begin
      n.a = REF_W'(g.a - g.b) >> 1;
    end else begin
      n.b = REF_W'(g.b - g.a) >> 1;
    end
    gcd_step = n;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/pdc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pdc_req_if;
  logic                       valid;
  logic                       ready;
  logic [pdc_pkg::RATE_W-1:0] rate_hz;
  logic                       pll_select;
  modport source(output valid, rate_hz, pll_select, input ready);
  modport sink(input valid, rate_hz, pll_select, output ready);
endinterface

interface pdc_res_if;
  logic                       valid;
  logic                       ready;
  logic [pdc_pkg::ST_W-1:0]   status;
  logic                       pll_id;
  logic [pdc_pkg::DP_W-1:0]   post_div;
  logic [pdc_pkg::FB_W-1:0]   feedback_div;
  logic [pdc_pkg::REF_W-1:0]  ref_div;
  logic [pdc_pkg::FRAC_W-1:0] frac_value;
  modport source(output valid, status, pll_id, post_div, feedback_div, ref_div, frac_value,
                 input ready);
  modport sink(input valid, status, pll_id, post_div, feedback_div, ref_div, frac_value,
               output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/pll_divider_calculator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// PLL divider calculator. Each request carries a rate in Hz and a PLL select and yields one
// result with status, post, feedback and reference dividers and a fraction. The datapath is a
// fully pipelined chain: three front stages (range check and reciprocal multiply to MHz, post
// divider multiples, post divider pick), then 39 one-bit stages for the restoring divisions
// and the binary gcd, then the output register. A request is taken every cycle unless the
// output stalls, and a stalled output freezes the whole pipe. Write cfg registers only while
// no request is in flight.
module pll_divider_calculator_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pdc_req_if.sink                            in_req,
  pdc_res_if.source                          out_res,
  input  wire logic                          cfg_we,
  input  wire logic [pdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pdc_pkg::CFG_W-1:0]     cfg_wdata
);
  import pdc_pkg::*;

  logic [REF_W-1:0]  refc_r;
  logic [VMIN_W-1:0] vmin_r;
  logic              adv;
  core_t             front_item, last;

  logic              out_valid_r;
  status_t           status_r, status_nxt;
  logic              pll_r;
  logic [DP_W-1:0]   post_r, post_nxt;
  logic [FB_W-1:0]   fb_r, fb_nxt;
  logic [REF_W-1:0]  ref_r, ref_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [FRAC_BITS:0] fsum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refc_r <= REF_CLOCK_RST;
      vmin_r <= VCO_MIN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_REF_CLOCK: refc_r <= cfg_wdata[REF_W-1:0];
        REG_VCO_MIN:   vmin_r <= cfg_wdata[VMIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign adv          = !out_valid_r || out_res.ready;
  assign in_req.ready = adv;

  pdc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_req.valid),
    .in_rate_hz (in_req.rate_hz),
    .in_pll     (in_req.pll_select),
    .refc       (refc_r),
    .vmin       (vmin_r),
    .out_item   (front_item)
  );

  pdc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .refc     (refc_r),
    .in_item  (front_item),
    .out_item (last)
  );

  assign fsum = {1'b0, last.main_q[FRAC_BITS-1:0]} + (FRAC_BITS + 1)'(1);

  always_comb begin
    status_nxt = last.status;
    post_nxt   = '0;
    fb_nxt     = '0;
    ref_nxt    = '0;
    frac_nxt   = '0;
    if (last.status == ST_OK) begin
      if (last.quo_n > R_W'(MAX_FB_DIV)) begin
        if (last.main_q[MAIN_W-1 -: R_W] > R_W'(MAX_FB_DIV)) begin
          status_nxt = ST_RANGE;
        end else begin
          post_nxt = last.dp;
          fb_nxt   = last.main_q[FRAC_BITS +: FB_W];
          ref_nxt  = REF_W'(1);
          frac_nxt = FRAC_W'(fsum);
        end
      end else begin
        post_nxt = last.dp;
        fb_nxt   = last.quo_n[FB_W-1:0];
        ref_nxt  = last.quo_m[REF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= status_nxt;
      pll_r    <= last.pll;
      post_r   <= post_nxt;
      fb_r     <= fb_nxt;
      ref_r    <= ref_nxt;
      frac_r   <= frac_nxt;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.status       = status_r;
  assign out_res.pll_id       = pll_r;
  assign out_res.post_div     = post_r;
  assign out_res.feedback_div = fb_r;
  assign out_res.ref_div      = ref_r;
  assign out_res.frac_value   = frac_r;

`ifndef SYNTHESIS
  a_ok_nonzero_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.status == ST_OK) |-> (out_res.post_div != '0 &&
      out_res.ref_div != '0))
    else $error("ok result with zero divider");

  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.status != ST_OK) |-> (out_res.post_div == '0 &&
      out_res.feedback_div == '0 && out_res.ref_div == '0 && out_res.frac_value == '0))
    else $error("error result with nonzero fields");

  a_int_mode_no_frac: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.status == ST_OK && out_res.ref_div != REF_W'(1)) |->
      (out_res.frac_value == '0))
    else $error("fraction set with reference divider above one");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/pdc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pdc_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire logic                       in_valid,
  input  wire logic [pdc_pkg::RATE_W-1:0] in_rate_hz,
  input  wire logic                       in_pll,
  input  wire logic [pdc_pkg::REF_W-1:0]  refc,
  input  wire logic [pdc_pkg::VMIN_W-1:0] vmin,
  output pdc_pkg::core_t                  out_item
);
  import pdc_pkg::*;

  logic              v1_r, pll1_r, hi1_r;
  logic [PROD_W-1:0] prod1_r;
  logic              v2_r, pll2_r, hi2_r;
  logic [R_W-1:0]    r2_r;
  logic [MUL_W-1:0]  mul_r [NUM_MUL];
  logic [MUL_W-1:0]  mul_nxt [NUM_MUL];
  logic [R_W-1:0]    r_nxt;
  core_t             item_r, item_nxt;

  // rate to whole MHz by reciprocal multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pll1_r  <= in_pll;
      hi1_r   <= in_rate_hz > MAX_RATE_HZ;
      prod1_r <= PROD_W'(in_rate_hz) * PROD_W'(RECIP_MHZ);
    end
  end

  // multiples of r for the post divider
  assign r_nxt = prod1_r[RECIP_SHIFT +: R_W];

  always_comb begin
    for (int k = 0; k < NUM_MUL; k++) begin
      mul_nxt[k] = MUL_W'(r_nxt) * MUL_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pll2_r <= pll1_r;
      hi2_r  <= hi1_r;
      r2_r   <= r_nxt;
      for (int k = 0; k < NUM_MUL; k++) begin
        mul_r[k] <= mul_nxt[k];
      end
    end
  end

  // post divider pick
  always_comb begin
    logic            found;
    logic [DP_W-1:0] dp;
    found = 1'b0;
    dp    = DP_W'(1);
    if (MUL_W'(r2_r) >= MUL_W'(vmin)) begin
      found = 1'b1;
    end else begin
      for (int d = MAX_POST_DIV; d >= 2; d--) begin
        if (mul_r[d] > MUL_W'(vmin)) begin
          found = 1'b1;
          dp    = DP_W'(d);
        end
      end
    end
    item_nxt        = '0;
    item_nxt.valid  = v2_r;
    item_nxt.pll    = pll2_r;
    item_nxt.dp     = dp;
    item_nxt.r2     = mul_r[dp][R_W-1:0];
    item_nxt.main_q = {mul_r[dp][R_W-1:0], FRAC_BITS'(0)};
    if (hi2_r) begin
      item_nxt.status = ST_TOO_HIGH;
    end else if (r2_r == '0 || refc == '0 || !found) begin
      item_nxt.status = ST_RANGE;
    end else begin
      item_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign out_item = item_r;

endmodule
`default_nettype wire

FILE: hw/rtl/pdc_core.sv
`timescale 1ns / 1ps
`default_nettype none
module pdc_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      adv,
  input  wire logic [pdc_pkg::REF_W-1:0] refc,
  input  pdc_pkg::core_t                 in_item,
  output pdc_pkg::core_t                 out_item
);
  import pdc_pkg::*;

  core_t stage_r   [CORE_STAGES];
  core_t stage_nxt [CORE_STAGES];

  for (genvar i = 0; i < CORE_STAGES; i++) begin : g_stage
    always_comb begin
      core_t          s;
      logic [REF_W:0] st;
      if (i == 0) begin
        s = in_item;
      end else begin
        s = stage_r[(i == 0) ? 0 : i - 1];
      end
      // gcd(refc, r2 mod refc) once the integer part is done
      if (i == GCD_START) begin
        s.gcd.a = refc;
        s.gcd.b = s.rem;
        s.gcd.k = '0;
      end else if (i > GCD_START && i <= GCD_START + GCD_STEPS) begin
        s.gcd = gcd_step(s.gcd);
      end
      if (i == QUO_START) begin
        s.gdiv  = REF_W'((s.gcd.a | s.gcd.b) << s.gcd.k);
        s.rem_n = '0;
        s.quo_n = s.r2;
        s.rem_m = '0;
        s.quo_m = R_W'(refc);
      end
      // (r2 << frac) / refc, one bit per stage
      if (i < MAIN_STEPS) begin
        st       = div_step(s.rem, s.main_q[MAIN_W-1], refc);
        s.rem    = st[REF_W-1:0];
        s.main_q = {s.main_q[MAIN_W-2:0], st[REF_W]};
      end
      // reduced dividers r2 / g and refc / g
      if (i >= QUO_START && i < QUO_END) begin
        st      = div_step(s.rem_n, s.quo_n[R_W-1], s.gdiv);
        s.rem_n = st[REF_W-1:0];
        s.quo_n = {s.quo_n[R_W-2:0], st[REF_W]};
        st      = div_step(s.rem_m, s.quo_m[R_W-1], s.gdiv);
        s.rem_m = st[REF_W-1:0];
        s.quo_m = {s.quo_m[R_W-2:0], st[REF_W]};
      end
      stage_nxt[i] = s;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r[i].valid <= 1'b0;
      end else if (adv) begin
        stage_r[i] <= stage_nxt[i];
      end
    end
  end

  assign out_item = stage_r[CORE_STAGES-1];

endmodule
`default_nettype wire
